FILE: rtl/plane_from_points_distance_assert.svh
// Assertion macros used by the RTL
`ifndef PLANE_FROM_POINTS_DISTANCE_ASSERT_SVH
`define PLANE_FROM_POINTS_DISTANCE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PFPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PFPD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`define PFPD_ASSERT_DLY(lbl, clk, rstn, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##n (cons)) \
    else $error("assertion failed");
`else
`define PFPD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PFPD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`define PFPD_ASSERT_DLY(lbl, clk, rstn, ante, n, cons)
`endif
`endif

FILE: rtl/pfpd_pkg.sv
package pfpd_pkg;

  // width of the distance result
  localparam int DIST_BITS = 34;

  // control that travels with each item down the root search
  typedef struct packed {
    logic valid;
    logic neg;
    logic degen;
  } ctl_t;

endpackage

FILE: rtl/pfpd_root_step.sv
module pfpd_root_step #(
  parameter int K  = 0,
  parameter int WB = 8,
  parameter int RB = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pfpd_pkg::ctl_t       ctl_i,
  input  logic signed [WB-1:0] s_i,
  input  logic signed [WB-1:0] l_i,
  input  logic signed [WB-1:0] e_i,
  input  logic signed [WB-1:0] g_i,
  input  logic        [RB-1:0] r_i,
  output pfpd_pkg::ctl_t       ctl_o,
  output logic signed [WB-1:0] s_o,
  output logic signed [WB-1:0] l_o,
  output logic signed [WB-1:0] e_o,
  output logic signed [WB-1:0] g_o,
  output logic        [RB-1:0] r_o
);

  // e = (2r-1)^2 s, g = (2r-1) s; trial of bit K
  logic signed [WB-1:0] cand;
  logic                 take;
  logic signed [WB-1:0] e_d, g_d;
  logic        [RB-1:0] r_d;

  assign cand = e_i + (g_i <<< (K + 2)) + (s_i <<< (2 * K + 2));
  assign take = (cand <= l_i);
  assign e_d  = take ? cand : e_i;
  assign g_d  = take ? (g_i + (s_i <<< (K + 1))) : g_i;
  assign r_d  = take ? (r_i | (RB'(1) << K)) : r_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s_o <= s_i;
    l_o <= l_i;
    e_o <= e_d;
    g_o <= g_d;
    r_o <= r_d;
  end

endmodule

FILE: rtl/plane_from_points_distance.sv
// Point-to-plane distance, fully pipelined. One item may be started in every
// cycle (busy_o stays low); its result appears on done_o after the front
// stages, the root search and the output register. Distance is found by the rounded
// square-root division, which resolves one result bit
// per pipeline stage. Results cannot be held off: each is valid for the one
// cycle that done_o is high. The distance is rounded to nearest, ties away
// from zero, and is 0 with degenerate_o set when the three points are collinear.
`include "plane_from_points_distance_assert.svh"

module plane_from_points_distance #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [COORD_BITS-1:0]     p1_x_i,
  input  logic signed [COORD_BITS-1:0]     p1_y_i,
  input  logic signed [COORD_BITS-1:0]     p1_z_i,
  input  logic signed [COORD_BITS-1:0]     p2_x_i,
  input  logic signed [COORD_BITS-1:0]     p2_y_i,
  input  logic signed [COORD_BITS-1:0]     p2_z_i,
  input  logic signed [COORD_BITS-1:0]     p3_x_i,
  input  logic signed [COORD_BITS-1:0]     p3_y_i,
  input  logic signed [COORD_BITS-1:0]     p3_z_i,
  input  logic signed [COORD_BITS-1:0]     q_x_i,
  input  logic signed [COORD_BITS-1:0]     q_y_i,
  input  logic signed [COORD_BITS-1:0]     q_z_i,
  output logic                             done_o,
  output logic signed [2*COORD_BITS+1:0]   coef_a_o,
  output logic signed [2*COORD_BITS+1:0]   coef_b_o,
  output logic signed [2*COORD_BITS+1:0]   coef_c_o,
  output logic signed [3*COORD_BITS+2:0]   coef_d_o,
  output logic signed [pfpd_pkg::DIST_BITS-1:0] signed_distance_o,
  output logic                             degenerate_o
);

  localparam int CB   = COORD_BITS;
  localparam int DB   = CB + 1;             // coordinate differences
  localparam int AB   = 2 * DB;             // normal components
  localparam int DWB  = AB + CB + 1;        // plane offset
  localparam int NB   = AB + DB + 2;        // numerator
  localparam int SB   = 2 * AB + 2;         // squared norm
  localparam int TOP  = CB + FRAC_BITS + 2; // highest result bit searched
  localparam int RB   = TOP + 1;
  localparam int WB   = 2 * TOP + SB + 6;   // search arithmetic
  localparam int LOB  = NB / 2;
  localparam int HIB  = NB - LOB;
  localparam int CFW  = 3 * AB + DWB;
  localparam int DW   = pfpd_pkg::DIST_BITS;
  localparam int CMPB = (RB > DW + 1) ? RB : DW + 1;
  localparam int NST  = TOP + 1;
  localparam int LAT  = TOP + 10;

  assign busy_o = 1'b0;

  logic [8:1] v_q;
  logic       acc;
  assign acc = start_i && !busy_o;

  // valid bits for the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[7:1], acc};
    end
  end

  // stage 1: differences to the first point
  logic signed [DB-1:0] dx2_q, dy2_q, dz2_q, dx3_q, dy3_q, dz3_q, vx_q, vy_q, vz_q;
  logic signed [CB-1:0] x1_q, y1_q, z1_q;
  always_ff @(posedge clk_i) begin
    dx2_q <= $signed({p2_x_i[CB-1], p2_x_i}) - $signed({p1_x_i[CB-1], p1_x_i});
    dy2_q <= $signed({p2_y_i[CB-1], p2_y_i}) - $signed({p1_y_i[CB-1], p1_y_i});
    dz2_q <= $signed({p2_z_i[CB-1], p2_z_i}) - $signed({p1_z_i[CB-1], p1_z_i});
    dx3_q <= $signed({p3_x_i[CB-1], p3_x_i}) - $signed({p1_x_i[CB-1], p1_x_i});
    dy3_q <= $signed({p3_y_i[CB-1], p3_y_i}) - $signed({p1_y_i[CB-1], p1_y_i});
    dz3_q <= $signed({p3_z_i[CB-1], p3_z_i}) - $signed({p1_z_i[CB-1], p1_z_i});
    vx_q  <= $signed({q_x_i[CB-1], q_x_i}) - $signed({p1_x_i[CB-1], p1_x_i});
    vy_q  <= $signed({q_y_i[CB-1], q_y_i}) - $signed({p1_y_i[CB-1], p1_y_i});
    vz_q  <= $signed({q_z_i[CB-1], q_z_i}) - $signed({p1_z_i[CB-1], p1_z_i});
    x1_q  <= p1_x_i;
    y1_q  <= p1_y_i;
    z1_q  <= p1_z_i;
  end

  // stage 2: cross product terms
  logic signed [AB-1:0] m_yz_q, m_zy_q, m_zx_q, m_xz_q, m_xy_q, m_yx_q;
  logic signed [DB-1:0] vx2_q, vy2_q, vz2_q;
  logic signed [CB-1:0] x2_q, y2_q, z2_q;
  always_ff @(posedge clk_i) begin
    m_yz_q <= dy2_q * dz3_q;
    m_zy_q <= dz2_q * dy3_q;
    m_zx_q <= dz2_q * dx3_q;
    m_xz_q <= dx2_q * dz3_q;
    m_xy_q <= dx2_q * dy3_q;
    m_yx_q <= dy2_q * dx3_q;
    vx2_q  <= vx_q;
    vy2_q  <= vy_q;
    vz2_q  <= vz_q;
    x2_q   <= x1_q;
    y2_q   <= y1_q;
    z2_q   <= z1_q;
  end

  // stage 3: normal
  logic signed [AB-1:0] a_q, b_q, c_q;
  logic signed [DB-1:0] vx3_q, vy3_q, vz3_q;
  logic signed [CB-1:0] x3_q, y3_q, z3_q;
  always_ff @(posedge clk_i) begin
    a_q   <= m_yz_q - m_zy_q;
    b_q   <= m_zx_q - m_xz_q;
    c_q   <= m_xy_q - m_yx_q;
    vx3_q <= vx2_q;
    vy3_q <= vy2_q;
    vz3_q <= vz2_q;
    x3_q  <= x2_q;
    y3_q  <= y2_q;
    z3_q  <= z2_q;
  end

  // stage 4: dot products and squares
  logic signed [AB+CB-1:0] pax_q, pby_q, pcz_q;
  logic signed [AB+DB-1:0] pav_q, pbv_q, pcv_q;
  logic signed [2*AB-1:0]  paa_q, pbb_q, pcc_q;
  logic        [3*AB-1:0]  abc4_q;
  logic                    degen4_q;
  always_ff @(posedge clk_i) begin
    pax_q    <= a_q * x3_q;
    pby_q    <= b_q * y3_q;
    pcz_q    <= c_q * z3_q;
    pav_q    <= a_q * vx3_q;
    pbv_q    <= b_q * vy3_q;
    pcv_q    <= c_q * vz3_q;
    paa_q    <= a_q * a_q;
    pbb_q    <= b_q * b_q;
    pcc_q    <= c_q * c_q;
    abc4_q   <= {a_q, b_q, c_q};
    degen4_q <= (a_q == '0) && (b_q == '0) && (c_q == '0);
  end

  // stage 5: offset, numerator, squared norm
  logic signed [DWB-1:0] d_d;
  logic signed [NB-1:0]  num_d, num_q;
  logic signed [SB-1:0]  s_d, s5_q;
  logic        [CFW-1:0] coef5_q;
  logic                  degen5_q;
  assign d_d   = -(pax_q + pby_q + pcz_q);
  assign num_d = pav_q + pbv_q + pcv_q;
  assign s_d   = paa_q + pbb_q + pcc_q;
  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    s5_q     <= s_d;
    coef5_q  <= {abc4_q, d_d};
    degen5_q <= degen4_q;
  end

  // stage 6: magnitude and sign
  logic [NB-1:0]        mag_q;
  logic                 neg6_q, degen6_q;
  logic signed [SB-1:0] s6_q;
  logic [CFW-1:0]       coef6_q;
  always_ff @(posedge clk_i) begin
    mag_q    <= num_q[NB-1] ? NB'(-num_q) : NB'(num_q);
    neg6_q   <= num_q[NB-1];
    degen6_q <= degen5_q;
    s6_q     <= s5_q;
    coef6_q  <= coef5_q;
  end

  // stage 7: partial products of the squared magnitude
  logic [2*HIB-1:0]     pp_hh_q;
  logic [HIB+LOB-1:0]   pp_hl_q;
  logic [2*LOB-1:0]     pp_ll_q;
  logic [HIB-1:0]       mag_hi;
  logic [LOB-1:0]       mag_lo;
  logic                 neg7_q, degen7_q;
  logic signed [SB-1:0] s7_q;
  logic [CFW-1:0]       coef7_q;
  assign mag_hi = mag_q[NB-1:LOB];
  assign mag_lo = mag_q[LOB-1:0];
  always_ff @(posedge clk_i) begin
    pp_hh_q  <= mag_hi * mag_hi;
    pp_hl_q  <= mag_hi * mag_lo;
    pp_ll_q  <= mag_lo * mag_lo;
    neg7_q   <= neg6_q;
    degen7_q <= degen6_q;
    s7_q     <= s6_q;
    coef7_q  <= coef6_q;
  end

  // stage 8: limit 4*(mag << FRAC)^2 and search start values
  logic signed [WB-1:0] l_d, s_w;
  logic signed [WB-1:0] l8_q, s8_q, e8_q, g8_q;
  pfpd_pkg::ctl_t       ctl8;
  logic                 neg8_q, degen8_q;
  logic [CFW-1:0]       coef8_q;
  assign l_d = $signed((WB'(pp_hh_q) << (2 * LOB + 2 * FRAC_BITS + 2))
             + (WB'(pp_hl_q) << (LOB + 2 * FRAC_BITS + 3))
             + (WB'(pp_ll_q) << (2 * FRAC_BITS + 2)));
  assign s_w = WB'(s7_q);
  always_ff @(posedge clk_i) begin
    l8_q     <= l_d;
    s8_q     <= s_w;
    e8_q     <= s_w;
    g8_q     <= -s_w;
    neg8_q   <= neg7_q;
    degen8_q <= degen7_q;
    coef8_q  <= coef7_q;
  end
  assign ctl8 = '{valid: v_q[8], neg: neg8_q, degen: degen8_q};

  // root search, one result bit per stage, highest first
  pfpd_pkg::ctl_t       ctl_s [0:NST];
  logic signed [WB-1:0] s_s   [0:NST];
  logic signed [WB-1:0] l_s   [0:NST];
  logic signed [WB-1:0] e_s   [0:NST];
  logic signed [WB-1:0] g_s   [0:NST];
  logic [RB-1:0]        r_s   [0:NST];
  logic [CFW-1:0]       coef_s[0:NST];

  assign ctl_s[0]  = ctl8;
  assign s_s[0]    = s8_q;
  assign l_s[0]    = l8_q;
  assign e_s[0]    = e8_q;
  assign g_s[0]    = g8_q;
  assign r_s[0]    = '0;
  assign coef_s[0] = coef8_q;

  for (genvar i = 0; i < NST; i++) begin : g_step
    pfpd_root_step #(
      .K (TOP - i),
      .WB(WB),
      .RB(RB)
    ) u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl_s[i]),
      .s_i   (s_s[i]),
      .l_i   (l_s[i]),
      .e_i   (e_s[i]),
      .g_i   (g_s[i]),
      .r_i   (r_s[i]),
      .ctl_o (ctl_s[i+1]),
      .s_o   (s_s[i+1]),
      .l_o   (l_s[i+1]),
      .e_o   (e_s[i+1]),
      .g_o   (g_s[i+1]),
      .r_o   (r_s[i+1])
    );

    // coefficients ride along
    always_ff @(posedge clk_i) begin
      coef_s[i+1] <= coef_s[i];
    end
  end

  // final stage: saturate, apply sign, degenerate case
  logic [CMPB-1:0] r_ext, r_sat;
  logic [DW-1:0]   dist_d;
  logic            done_q;
  assign r_ext = CMPB'(r_s[NST]);
  always_comb begin
    if (ctl_s[NST].neg) begin
      r_sat = (r_ext > (CMPB'(1) << (DW - 1))) ? (CMPB'(1) << (DW - 1)) : r_ext;
    end else begin
      r_sat = (r_ext > ((CMPB'(1) << (DW - 1)) - CMPB'(1)))
            ? ((CMPB'(1) << (DW - 1)) - CMPB'(1)) : r_ext;
    end
    if (ctl_s[NST].degen) begin
      dist_d = '0;
    end else if (ctl_s[NST].neg) begin
      dist_d = DW'(-r_sat);
    end else begin
      dist_d = DW'(r_sat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_s[NST].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_a_o          <= coef_s[NST][CFW-1 -: AB];
    coef_b_o          <= coef_s[NST][CFW-AB-1 -: AB];
    coef_c_o          <= coef_s[NST][CFW-2*AB-1 -: AB];
    coef_d_o          <= coef_s[NST][DWB-1:0];
    signed_distance_o <= $signed(dist_d);
    degenerate_o      <= ctl_s[NST].degen;
  end

  assign done_o = done_q;

  // checks
  `PFPD_ASSERT_DLY(a_latency, clk_i, rst_ni, acc, LAT, done_o)
  `PFPD_ASSERT_NXT(a_enter, clk_i, rst_ni, acc, v_q[1])
  `PFPD_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, done_o && degenerate_o, (signed_distance_o == '0) && (coef_a_o == '0) && (coef_b_o == '0) && (coef_c_o == '0))

endmodule
